// ===== rtl/thc_pkg.sv =====
`timescale 1ns / 1ps
package thc_pkg;

   localparam int DEF_CORDIC_STAGES = 16;
   localparam int TAB_LEN = 24;

   // Rotation datapath widths: sine/cosine lane and heading lane.
   localparam int SC_XW = 34;
   localparam int SC_ZW = 28;
   localparam int HD_XW = 54;
   localparam int HD_ZW = 29;

   localparam logic signed [SC_XW-1:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [HD_ZW-1:0] HALF_TURN = 29'sd73728000;

   // atan(2^-i) in 1/409600 degree.
   localparam logic signed [27:0] ATAN_TAB [0:TAB_LEN-1] = '{
      28'sd18432000, 28'sd10881045, 28'sd5749245, 28'sd2918407,
      28'sd1464867, 28'sd733147, 28'sd366663, 28'sd183343,
      28'sd91673, 28'sd45837, 28'sd22918, 28'sd11459,
      28'sd5730, 28'sd2865, 28'sd1432, 28'sd716,
      28'sd358, 28'sd179, 28'sd90, 28'sd45,
      28'sd22, 28'sd11, 28'sd6, 28'sd3
   };

   typedef enum logic [2:0] {
      REG_HARD_IRON_X = 3'd0,
      REG_HARD_IRON_Y = 3'd1,
      REG_SCALE_X     = 3'd2,
      REG_SCALE_Y     = 3'd3,
      REG_ENV_X       = 3'd4,
      REG_ENV_Y       = 3'd5,
      REG_ENV_EN      = 3'd6,
      REG_QUALITY     = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic flip;
      logic signed [SC_ZW-1:0] z;
   } angle_red_type;

   typedef struct packed {
      logic signed [15:0] mx;
      logic signed [15:0] my;
      logic signed [15:0] mz;
      logic flip_p;
      logic flip_r;
   } mag_sb_type;

   typedef struct packed {
      logic [15:0] pitch;
      logic [15:0] roll;
   } angles_type;

   typedef struct packed {
      logic zero;
      logic [15:0] pitch;
      logic [15:0] roll;
   } hd_sb_type;

   // Wraps an angle into one quadrant pair and scales it for the rotation chain.
   function automatic angle_red_type reduce_angle(input logic signed [15:0] ang);
      logic signed [17:0] a;
      angle_red_type r;
      a = 18'(ang);
      r.flip = 1'b0;
      if (a >= 18'sd18000) a = a - 18'sd36000;
      if (a < -18'sd18000) a = a + 18'sd36000;
      if (a > 18'sd9000) begin
         a = a - 18'sd18000;
         r.flip = 1'b1;
      end else if (a < -18'sd9000) begin
         a = a + 18'sd18000;
         r.flip = 1'b1;
      end
      r.z = SC_ZW'(a) <<< 12;
      return r;
   endfunction

   function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                 input int s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [63:0] v);
      logic signed [19:0] r;
      if (v > 64'sd524287) r = 20'sd524287;
      else if (v < -64'sd524288) r = -20'sd524288;
      else r = 20'(v);
      return r;
   endfunction

   // Rounds a rotation output to Q1.15, clamps it to plus or minus one and negates it when flip is set.
   function automatic logic signed [16:0] to_q15(input logic signed [SC_XW-1:0] x,
                                                 input logic flip);
      logic signed [63:0] t;
      logic signed [16:0] r;
      t = rnd_sh(64'(x), 15);
      if (t > 64'sd32768) r = 17'sd32768;
      else if (t < -64'sd32768) r = -17'sd32768;
      else r = 17'(t);
      if (flip) r = -r;
      return r;
   endfunction

endpackage

// ===== rtl/thc_rot_cell.sv =====
`timescale 1ns / 1ps
module thc_rot_cell #(
   parameter int STAGE = 0,
   parameter int XW = 34,
   parameter int ZW = 28
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [XW-1:0] x_prev,
   input  logic signed [XW-1:0] y_prev,
   input  logic signed [ZW-1:0] z_prev,
   output logic signed [XW-1:0] x_next,
   output logic signed [XW-1:0] y_next,
   output logic signed [ZW-1:0] z_next
);
   import thc_pkg::*;

   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in, step;

   assign step = ZW'(ATAN_TAB[STAGE]);

   always_comb begin
      if (z_prev >= 0) begin
         x_in = x_prev - (y_prev >>> STAGE);
         y_in = y_prev + (x_prev >>> STAGE);
         z_in = z_prev - step;
      end else begin
         x_in = x_prev + (y_prev >>> STAGE);
         y_in = y_prev - (x_prev >>> STAGE);
         z_in = z_prev + step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_next = x_ff;
   assign y_next = y_ff;
   assign z_next = z_ff;

endmodule

// ===== rtl/thc_vec_cell.sv =====
`timescale 1ns / 1ps
module thc_vec_cell #(
   parameter int STAGE = 0,
   parameter int XW = 54,
   parameter int ZW = 29
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [XW-1:0] u_prev,
   input  logic signed [XW-1:0] v_prev,
   input  logic signed [ZW-1:0] z_prev,
   output logic signed [XW-1:0] u_next,
   output logic signed [XW-1:0] v_next,
   output logic signed [ZW-1:0] z_next
);
   import thc_pkg::*;

   logic signed [XW-1:0] u_ff, u_in, v_ff, v_in;
   logic signed [ZW-1:0] z_ff, z_in, step;

   assign step = ZW'(ATAN_TAB[STAGE]);

   always_comb begin
      if (v_prev > 0) begin
         u_in = u_prev + (v_prev >>> STAGE);
         v_in = v_prev - (u_prev >>> STAGE);
         z_in = z_prev + step;
      end else begin
         u_in = u_prev - (v_prev >>> STAGE);
         v_in = v_prev + (u_prev >>> STAGE);
         z_in = z_prev - step;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
         v_ff <= v_in;
         z_ff <= z_in;
      end
   end

   assign u_next = u_ff;
   assign v_next = v_ff;
   assign z_next = z_ff;

endmodule

// ===== rtl/tilt_compensated_heading.sv =====
`timescale 1ns / 1ps
// Tilt-compensated compass heading.
// A sample (three field axes, pitch and roll) is taken on the req_ channel
// when req_valid and req_ready are both high. One result per sample leaves on
// the rsp_ channel in order: heading in 0.01 degree (0 to 35999), the pitch
// and roll bits unchanged and the configured quality score.
// The datapath is a single pipeline: angle reduction, a row of CORDIC_STAGES
// rotation cells for sine and cosine, eight stages of multiply, round and
// saturate for tilt and calibration, a row of CORDIC_STAGES vectoring cells
// for the angle, and the output register. A new sample is taken every
// cycle while the output is not stalled.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline holds and req_ready drops in the same cycle; nothing is lost.
// Reset empties the pipeline and loads the calibration registers with
// unity scale and zero offsets. The csr_ port writes one register per cycle
// and should only be used while no transfer is in flight.
module tilt_compensated_heading #(
   parameter int CORDIC_STAGES = thc_pkg::DEF_CORDIC_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_mag_x,
   input  logic signed [15:0] req_mag_y,
   input  logic signed [15:0] req_mag_z,
   input  logic signed [15:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_heading,
   output logic signed [15:0] rsp_pitch_out,
   output logic signed [15:0] rsp_roll_out,
   output logic [15:0] rsp_quality_out,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import thc_pkg::*;

   localparam int N = CORDIC_STAGES;
   localparam int MID = 8;

   logic adv;

   // Calibration registers.
   logic signed [15:0] hard_iron_x_ff, hard_iron_y_ff, env_x_ff, env_y_ff;
   logic [15:0] scale_x_ff, scale_y_ff, quality_ff;
   logic env_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hard_iron_x_ff <= '0;
         hard_iron_y_ff <= '0;
         scale_x_ff <= 16'd4096;
         scale_y_ff <= 16'd4096;
         env_x_ff <= '0;
         env_y_ff <= '0;
         env_en_ff <= 1'b0;
         quality_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_HARD_IRON_X: hard_iron_x_ff <= csr_wdata;
            REG_HARD_IRON_Y: hard_iron_y_ff <= csr_wdata;
            REG_SCALE_X:     scale_x_ff <= csr_wdata;
            REG_SCALE_Y:     scale_y_ff <= csr_wdata;
            REG_ENV_X:       env_x_ff <= csr_wdata;
            REG_ENV_Y:       env_y_ff <= csr_wdata;
            REG_ENV_EN:      env_en_ff <= csr_wdata[0];
            REG_QUALITY:     quality_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Valid bits of every stage.
   logic vlda_ff;
   logic [N-1:0] vld1_ff;
   logic [MID-1:0] vmid_ff;
   logic [N-1:0] vld2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff <= 1'b0;
         vld1_ff <= '0;
         vmid_ff <= '0;
         vld2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vlda_ff <= req_valid;
         vld1_ff <= {vld1_ff[N-2:0], vlda_ff};
         vmid_ff <= {vmid_ff[MID-2:0], vld1_ff[N-1]};
         vld2_ff <= {vld2_ff[N-2:0], vmid_ff[MID-1]};
         rsp_valid_ff <= vld2_ff[N-1];
      end
   end

   // Angle reduction.
   angle_red_type red_p, red_r;
   logic signed [SC_ZW-1:0] zp_ff, zr_ff;
   mag_sb_type sba_ff;
   angles_type ana_ff;

   assign red_p = reduce_angle(req_pitch_angle);
   assign red_r = reduce_angle(req_roll_angle);

   always_ff @(posedge clock) begin
      if (adv) begin
         zp_ff <= red_p.z;
         zr_ff <= red_r.z;
         sba_ff <= '{mx: req_mag_x, my: req_mag_y, mz: req_mag_z,
                     flip_p: red_p.flip, flip_r: red_r.flip};
         ana_ff <= '{pitch: req_pitch_angle, roll: req_roll_angle};
      end
   end

   // Sine and cosine rows, one cell per iteration for each angle.
   logic signed [SC_XW-1:0] xp_w [0:N], yp_w [0:N], xr_w [0:N], yr_w [0:N];
   logic signed [SC_ZW-1:0] zp_w [0:N], zr_w [0:N];
   mag_sb_type sb1_ff [0:N-1];
   angles_type an1_ff [0:N-1];

   assign xp_w[0] = CORDIC_K;
   assign yp_w[0] = '0;
   assign zp_w[0] = zp_ff;
   assign xr_w[0] = CORDIC_K;
   assign yr_w[0] = '0;
   assign zr_w[0] = zr_ff;

   for (genvar k = 0; k < N; k++) begin : g_rot
      thc_rot_cell #(.STAGE(k), .XW(SC_XW), .ZW(SC_ZW)) u_pitch (
         .clock(clock), .en(adv),
         .x_prev(xp_w[k]), .y_prev(yp_w[k]), .z_prev(zp_w[k]),
         .x_next(xp_w[k+1]), .y_next(yp_w[k+1]), .z_next(zp_w[k+1])
      );
      thc_rot_cell #(.STAGE(k), .XW(SC_XW), .ZW(SC_ZW)) u_roll (
         .clock(clock), .en(adv),
         .x_prev(xr_w[k]), .y_prev(yr_w[k]), .z_prev(zr_w[k]),
         .x_next(xr_w[k+1]), .y_next(yr_w[k+1]), .z_next(zr_w[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb1_ff[0] <= sba_ff;
         an1_ff[0] <= ana_ff;
         for (int k = 1; k < N; k++) begin
            sb1_ff[k] <= sb1_ff[k-1];
            an1_ff[k] <= an1_ff[k-1];
         end
      end
   end

   // Tilt and calibration stages B through I.
   angles_type anm_ff [0:MID-1];
   logic signed [16:0] cp_ff, sp_ff, cr_ff, sr_ff;
   logic signed [15:0] mxb_ff, myb_ff, mzb_ff, mxc_ff, mzc_ff;
   logic signed [32:0] pa_ff, pb_ff, ss_ff, sc_ff, myc_ff, mycd_ff;
   logic signed [49:0] t1_ff, t2_ff;
   logic signed [19:0] hx0_ff, hx1_ff, hx2_ff, hx3_ff, hy0_ff, hy1_ff, hy2_ff;
   logic signed [36:0] prodx_ff, prody_ff;
   logic signed [63:0] hy_sum;
   mag_sb_type sbn;

   assign sbn = sb1_ff[N-1];
   assign hy_sum = 64'(t1_ff) + (64'(mycd_ff) <<< 15) - 64'(t2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         anm_ff[0] <= an1_ff[N-1];
         for (int k = 1; k < MID; k++) anm_ff[k] <= anm_ff[k-1];
         // B: round sine and cosine.
         cp_ff <= to_q15(xp_w[N], sbn.flip_p);
         sp_ff <= to_q15(yp_w[N], sbn.flip_p);
         cr_ff <= to_q15(xr_w[N], sbn.flip_r);
         sr_ff <= to_q15(yr_w[N], sbn.flip_r);
         mxb_ff <= sbn.mx;
         myb_ff <= sbn.my;
         mzb_ff <= sbn.mz;
         // C: first products.
         pa_ff <= 33'(mxb_ff) * 33'(cp_ff);
         pb_ff <= 33'(mzb_ff) * 33'(sp_ff);
         ss_ff <= 33'(sr_ff) * 33'(sp_ff);
         sc_ff <= 33'(sr_ff) * 33'(cp_ff);
         myc_ff <= 33'(myb_ff) * 33'(cr_ff);
         mxc_ff <= mxb_ff;
         mzc_ff <= mzb_ff;
         // D: three-factor terms of y, x rounded.
         t1_ff <= 50'(mxc_ff) * 50'(ss_ff);
         t2_ff <= 50'(mzc_ff) * 50'(sc_ff);
         mycd_ff <= myc_ff;
         hx0_ff <= sat20(rnd_sh(64'(pa_ff) + 64'(pb_ff), 15));
         // E: y rounded, x hard iron.
         hy0_ff <= sat20(rnd_sh(hy_sum, 30));
         hx1_ff <= sat20(64'(hx0_ff) - 64'(hard_iron_x_ff));
         // F: y hard iron, x scale product.
         hy1_ff <= sat20(64'(hy0_ff) - 64'(hard_iron_y_ff));
         prodx_ff <= 37'(hx1_ff) * 37'(signed'({1'b0, scale_x_ff}));
         // G: x scaled, y scale product.
         hx2_ff <= sat20(rnd_sh(64'(prodx_ff), 12));
         prody_ff <= 37'(hy1_ff) * 37'(signed'({1'b0, scale_y_ff}));
         // H: y scaled, x environment offset.
         hy2_ff <= sat20(rnd_sh(64'(prody_ff), 12));
         hx3_ff <= env_en_ff ? sat20(64'(hx2_ff) - 64'(env_x_ff)) : hx2_ff;
      end
   end

   // I: y environment offset and start of the vectoring row.
   logic signed [19:0] hy3;
   logic signed [HD_XW-1:0] u0, v0, ui_ff, vi_ff;
   logic signed [HD_ZW-1:0] z0, zi_ff;
   logic zero_ff;

   always_comb begin
      hy3 = env_en_ff ? sat20(64'(hy2_ff) - 64'(env_y_ff)) : hy2_ff;
      u0 = HD_XW'(hx3_ff) <<< 30;
      v0 = -(HD_XW'(hy3) <<< 30);
      z0 = '0;
      // A vector in the left half plane is turned by half a turn first.
      if (hx3_ff < 0) begin
         z0 = (v0 >= 0) ? HALF_TURN : -HALF_TURN;
         u0 = -u0;
         v0 = -v0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ui_ff <= u0;
         vi_ff <= v0;
         zi_ff <= z0;
         zero_ff <= (hx3_ff == 0) && (hy3 == 0);
      end
   end

   logic signed [HD_XW-1:0] u_w [0:N], v_w [0:N];
   logic signed [HD_ZW-1:0] zh_w [0:N];
   hd_sb_type sb2_ff [0:N-1];

   assign u_w[0] = ui_ff;
   assign v_w[0] = vi_ff;
   assign zh_w[0] = zi_ff;

   for (genvar k = 0; k < N; k++) begin : g_vec
      thc_vec_cell #(.STAGE(k), .XW(HD_XW), .ZW(HD_ZW)) u_cell (
         .clock(clock), .en(adv),
         .u_prev(u_w[k]), .v_prev(v_w[k]), .z_prev(zh_w[k]),
         .u_next(u_w[k+1]), .v_next(v_w[k+1]), .z_next(zh_w[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb2_ff[0] <= '{zero: zero_ff, pitch: anm_ff[MID-1].pitch,
                        roll: anm_ff[MID-1].roll};
         for (int k = 1; k < N; k++) sb2_ff[k] <= sb2_ff[k-1];
      end
   end

   // Output register.
   logic signed [63:0] deg_r;
   logic signed [17:0] deg;
   logic [15:0] heading_ff;
   logic [15:0] pitch_o_ff, roll_o_ff;

   always_comb begin
      deg_r = rnd_sh(64'(zh_w[N]), 12);
      deg = 18'(deg_r);
      if (deg < 0) deg = deg + 18'sd36000;
      if (deg >= 18'sd36000) deg = deg - 18'sd36000;
      if (sb2_ff[N-1].zero) deg = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         heading_ff <= deg[15:0];
         pitch_o_ff <= sb2_ff[N-1].pitch;
         roll_o_ff <= sb2_ff[N-1].roll;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_heading = heading_ff;
   assign rsp_pitch_out = pitch_o_ff;
   assign rsp_roll_out = roll_o_ff;
   assign rsp_quality_out = quality_ff;

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_heading < 16'd36000)
      else $error("heading out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_q15_range: assert property (@(posedge clock) disable iff (reset)
      vmid_ff[0] |-> (cp_ff <= 17'sd32768 && cp_ff >= -17'sd32768 &&
                      sr_ff <= 17'sd32768 && sr_ff >= -17'sd32768))
      else $error("sine or cosine beyond unity");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (vmid_ff[MID-1] && !adv) |=> vmid_ff[MID-1])
      else $error("pipeline item lost during stall");

endmodule

// ===== tb/tb_tilt_compensated_heading.sv =====
`timescale 1ns / 1ps
module tb_tilt_compensated_heading;
   import thc_pkg::*;

   localparam int STAGES = 16;
   localparam int LATENCY = 2 * STAGES + 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint SAT_HI = 524287;
   localparam longint SAT_LO = -524288;

   localparam longint ARC_TAB [0:23] = '{
      18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
      91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
      358, 179, 90, 45, 22, 11, 6, 3
   };

   typedef struct {
      logic [15:0] heading;
      logic [15:0] pitch;
      logic [15:0] roll;
      logic [15:0] quality;
   } heading_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_mag_x = '0;
   logic signed [15:0] req_mag_y = '0;
   logic signed [15:0] req_mag_z = '0;
   logic signed [15:0] req_pitch_angle = '0;
   logic signed [15:0] req_roll_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_heading;
   logic signed [15:0] rsp_pitch_out;
   logic signed [15:0] rsp_roll_out;
   logic [15:0] rsp_quality_out;
   logic csr_wr_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // Calibration shadow of the block.
   logic signed [15:0] cal_hard_x, cal_hard_y, cal_env_x, cal_env_y;
   logic [15:0] cal_scale_x, cal_scale_y, cal_quality;
   logic cal_env_en;

   heading_result_t pending_headings[$];
   int mismatches = 0;
   int results_seen = 0;
   int samples_sent = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;
   bit pressure_free = 1'b0;

   tilt_compensated_heading i_dut (.*);

   always #5 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp20(longint v);
      return v < SAT_LO ? SAT_LO : (v > SAT_HI ? SAT_HI : v);
   endfunction

   function automatic void calc_sin_cos(input int ang, output longint sn,
                                        output longint cs);
      bit flip;
      longint x, y, z, xn;
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (ang >= 18000) ang -= 36000;
      if (ang < -18000) ang += 36000;
      if (ang > 9000) begin
         ang -= 18000;
         flip = 1'b1;
      end else if (ang < -9000) begin
         ang += 18000;
         flip = 1'b1;
      end
      z = longint'(ang) * 4096;
      for (int i = 0; i < STAGES; i++) begin
         if (z >= 0) begin
            xn = x - floor_shift(y, i); y = y + floor_shift(x, i); z -= ARC_TAB[i];
         end else begin
            xn = x + floor_shift(y, i); y = y - floor_shift(x, i); z += ARC_TAB[i];
         end
         x = xn;
      end
      cs = round_shift(x, 15);
      sn = round_shift(y, 15);
      cs = cs < -32768 ? -32768 : (cs > 32768 ? 32768 : cs);
      sn = sn < -32768 ? -32768 : (sn > 32768 ? 32768 : sn);
      if (flip) begin
         cs = -cs;
         sn = -sn;
      end
   endfunction

   function automatic logic [15:0] vector_angle(longint hx, longint hy);
      longint u, v, z, un, deg;
      u = hx * (longint'(1) <<< 30);
      v = -hy * (longint'(1) <<< 30);
      z = 0;
      if (u == 0 && v == 0) return 16'd0;
      if (u < 0) begin
         z = (v >= 0) ? 73728000 : -73728000;
         u = -u;
         v = -v;
      end
      for (int i = 0; i < STAGES; i++) begin
         if (v > 0) begin
            un = u + floor_shift(v, i); v = v - floor_shift(u, i); z += ARC_TAB[i];
         end else begin
            un = u - floor_shift(v, i); v = v + floor_shift(u, i); z -= ARC_TAB[i];
         end
         u = un;
      end
      deg = round_shift(z, 12);
      if (deg < 0) deg += 36000;
      if (deg >= 36000) deg -= 36000;
      return 16'(deg);
   endfunction

   function automatic heading_result_t predict_heading(logic signed [15:0] mx,
         logic signed [15:0] my, logic signed [15:0] mz, logic signed [15:0] pitch,
         logic signed [15:0] roll);
      heading_result_t r;
      longint sp, cp, sr, cr, hx, hy;
      calc_sin_cos(int'(pitch), sp, cp);
      calc_sin_cos(int'(roll), sr, cr);
      hx = clamp20(round_shift(longint'(mx) * cp + longint'(mz) * sp, 15));
      hy = clamp20(round_shift(longint'(mx) * sr * sp + longint'(my) * cr * 32768
                               - longint'(mz) * sr * cp, 30));
      hx = clamp20(hx - longint'(cal_hard_x));
      hy = clamp20(hy - longint'(cal_hard_y));
      hx = clamp20(round_shift(hx * longint'(cal_scale_x), 12));
      hy = clamp20(round_shift(hy * longint'(cal_scale_y), 12));
      if (cal_env_en) begin
         hx = clamp20(hx - longint'(cal_env_x));
         hy = clamp20(hy - longint'(cal_env_y));
      end
      r.heading = vector_angle(hx, hy);
      r.pitch = pitch;
      r.roll = roll;
      r.quality = cal_quality;
      return r;
   endfunction

   task automatic reset_shadow();
      cal_hard_x = 0; cal_hard_y = 0; cal_env_x = 0; cal_env_y = 0;
      cal_scale_x = 16'd4096; cal_scale_y = 16'd4096;
      cal_quality = 0; cal_env_en = 1'b0;
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_HARD_IRON_X: cal_hard_x = value;
         REG_HARD_IRON_Y: cal_hard_y = value;
         REG_SCALE_X:     cal_scale_x = value;
         REG_SCALE_Y:     cal_scale_y = value;
         REG_ENV_X:       cal_env_x = value;
         REG_ENV_Y:       cal_env_y = value;
         REG_ENV_EN:      cal_env_en = value[0];
         REG_QUALITY:     cal_quality = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_headings.size() != 0 && !timed_out) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Valid stays high after a transfer unless the next sample idles first, so
   // that back-to-back samples give one assignment per time step.
   task automatic send_sample(input logic signed [15:0] mx, input logic signed [15:0] my,
         input logic signed [15:0] mz, input logic signed [15:0] pitch,
         input logic signed [15:0] roll);
      while (!pressure_free && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mag_x <= mx;
      req_mag_y <= my;
      req_mag_z <= mz;
      req_pitch_angle <= pitch;
      req_roll_angle <= roll;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // The transfer has happened at this edge; queue its prediction.
      pending_headings.push_back(predict_heading(mx, my, mz, pitch, roll));
      samples_sent++;
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'(int'($urandom_range(36000)) - 18000);
         default: return 16'(int'($urandom_range(18000)) - 9000);
      endcase
   endfunction

   task automatic test_directed_extremes();
      send_sample(0, 0, 0, 0, 0);
      send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 18000, 18000);
      send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -18000, -18000);
      send_sample(1000, 0, 0, 0, 0);
      send_sample(0, 1000, 0, 0, 0);
      send_sample(-1000, 0, 0, 0, 0);
      send_sample(0, -1000, 0, 0, 0);
      send_sample(-1000, 1, 0, 0, 0);
      send_sample(-1000, -1, 0, 0, 0);
      send_sample(500, 300, -200, 9000, -9000);
      send_sample(500, 300, -200, 9001, -9001);
      send_sample(500, 300, -200, 16'sh7fff, -16'sh8000);
      send_sample(-700, 200, 900, 27000, -27000);
      send_sample(123, -456, 789, 35999, -35999);
      drain();
   endtask

   task automatic test_calibration_extremes();
      write_reg(REG_HARD_IRON_X, 16'h7fff);
      write_reg(REG_HARD_IRON_Y, 16'h8000);
      write_reg(REG_SCALE_X, 16'hffff);
      write_reg(REG_SCALE_Y, 16'h0000);
      write_reg(REG_ENV_X, 16'h8000);
      write_reg(REG_ENV_Y, 16'h7fff);
      write_reg(REG_ENV_EN, 16'hfffe);
      write_reg(REG_QUALITY, 16'h8000);
      send_sample(16'sh7fff, -16'sh8000, 0, 0, 0);
      send_sample(-300, 300, 0, 4500, 0);
      drain();
      write_reg(REG_ENV_EN, 16'h0001);
      send_sample(16'sh7fff, -16'sh8000, 0, 0, 0);
      send_sample(0, 0, 0, 0, 0);
      drain();
      write_reg(REG_SCALE_Y, 16'hffff);
      write_reg(REG_SCALE_X, 16'h0000);
      write_reg(REG_QUALITY, 16'hffff);
      send_sample(-16'sh8000, 16'sh7fff, 16'sh7fff, -9000, 9000);
      send_sample(0, 0, 0, 1234, -4321);
      drain();
   endtask

   task automatic test_random_samples(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            drain();
            write_reg(REG_HARD_IRON_X, ($urandom_range(1)) ? 16'($urandom)
                                                      : 16'($urandom_range(400)) - 16'd200);
            write_reg(REG_HARD_IRON_Y, ($urandom_range(1)) ? 16'($urandom)
                                                      : 16'($urandom_range(400)) - 16'd200);
            write_reg(REG_SCALE_X, ($urandom_range(3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(5000, 3000)));
            write_reg(REG_SCALE_Y, ($urandom_range(3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(5000, 3000)));
            write_reg(REG_ENV_X, 16'($urandom));
            write_reg(REG_ENV_Y, 16'($urandom));
            write_reg(REG_ENV_EN, 16'($urandom));
            write_reg(REG_QUALITY, 16'($urandom));
         end
         pressure_free = (i >= 400 && i < 500);
         if ($urandom_range(1))
            send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                        rand_angle(), rand_angle());
         else
            send_sample(16'(int'($urandom_range(8000)) - 4000),
                        16'(int'($urandom_range(8000)) - 4000),
                        16'(int'($urandom_range(8000)) - 4000),
                        rand_angle(), rand_angle());
      end
      pressure_free = 1'b0;
      drain();
   endtask

   // Result side: random back-pressure and in-order comparison.
   always @(posedge clock) begin
      heading_result_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_headings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result heading=%0d", rsp_heading);
            end else begin
               want = pending_headings.pop_front();
               if (want.heading !== rsp_heading || want.pitch !== rsp_pitch_out ||
                   want.roll !== rsp_roll_out || want.quality !== rsp_quality_out) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp h=%0d p=%0d r=%0d q=%0d got h=%0d p=%0d r=%0d q=%0d",
                              want.heading, $signed(want.pitch), $signed(want.roll),
                              want.quality, rsp_heading, rsp_pitch_out, rsp_roll_out,
                              rsp_quality_out);
               end
            end
         end
         rsp_ready <= pressure_free || ($urandom_range(99) >= 38);
      end
   end

   // The watchdog counts cycles without any transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         timed_out = 1'b1;
         $display("[tilt_compensated_heading] ERROR");
         $finish;
      end
   end

   initial begin
      reset_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_calibration_extremes();
      test_random_samples(1000);
      if (pending_headings.size() != 0) mismatches += pending_headings.size();
      $display("Ran %0d samples, %0d results checked, with calibration changes.",
               samples_sent, results_seen);
      if (mismatches == 0)
         $display("[tilt_compensated_heading] OK");
      else
         $display("[tilt_compensated_heading] ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/thc_pkg.sv
rtl/thc_rot_cell.sv
rtl/thc_vec_cell.sv
rtl/tilt_compensated_heading.sv
tb/tb_tilt_compensated_heading.sv
